### rtl/hldb_pkg.sv
// Shared types, constants and sample helpers for the luma deblocking segment filter.
`timescale 1ns / 1ps
package hldb_pkg;

    localparam int NLINES = 4;
    localparam int NSAMP  = 8;
    localparam int SAMP_W = 8;
    localparam int LINE_W = NSAMP * SAMP_W;

    localparam int IDX_P3 = 0;
    localparam int IDX_P2 = 1;
    localparam int IDX_P1 = 2;
    localparam int IDX_P0 = 3;
    localparam int IDX_Q0 = 4;
    localparam int IDX_Q1 = 5;
    localparam int IDX_Q2 = 6;
    localparam int IDX_Q3 = 7;

    typedef logic [SAMP_W-1:0] t_samp;
    typedef logic [LINE_W-1:0] t_line;

    typedef enum logic [1:0] {
        MODE_NONE   = 2'd0,
        MODE_WEAK   = 2'd1,
        MODE_STRONG = 2'd2
    } t_mode;

    typedef struct packed {
        t_line orig;
        t_samp sp2;
        t_samp sp1;
        t_samp sp0;
        t_samp sq0;
        t_samp sq1;
        t_samp sq2;
        logic  weak_ok;
        t_samp wp1;
        t_samp wp0;
        t_samp wq0;
        t_samp wq1;
    } t_lane_res;

    typedef struct packed {
        t_mode mode;
        logic  flat_p;
        logic  flat_q;
        logic  keep_p;
        logic  keep_q;
    } t_ctrl;

    function automatic t_samp get_samp(input t_line l, input int idx);
        return l[idx*SAMP_W +: SAMP_W];
    endfunction

    // clip a signed value to the sample range
    function automatic t_samp clip8(input logic signed [10:0] v);
        t_samp r;
        if (v < 11'sd0) begin
            r = '0;
        end else if (v > 11'sd255) begin
            r = 8'd255;
        end else begin
            r = v[7:0];
        end
        return r;
    endfunction

    // clamp to -lim..lim
    function automatic logic signed [10:0] clamp_sym(input logic signed [10:0] v,
                                                     input logic [4:0] lim);
        logic signed [10:0] hi;
        logic signed [10:0] lo;
        logic signed [10:0] r;
        hi = $signed({6'b0, lim});
        lo = -hi;
        if (v > hi) begin
            r = hi;
        end else if (v < lo) begin
            r = lo;
        end else begin
            r = v;
        end
        return r;
    endfunction

    // hold v within tc2 of x
    function automatic t_samp hold(input t_samp v, input t_samp x, input logic [5:0] tc2);
        logic signed [9:0] lo;
        logic signed [9:0] hi;
        logic signed [9:0] vs;
        t_samp r;
        lo = $signed({2'b0, x}) - $signed({4'b0, tc2});
        hi = $signed({2'b0, x}) + $signed({4'b0, tc2});
        vs = $signed({2'b0, v});
        if (vs < lo) begin
            r = lo[7:0];
        end else if (vs > hi) begin
            r = hi[7:0];
        end else begin
            r = v;
        end
        return r;
    endfunction

    function automatic logic [7:0] abs_diff(input t_samp a, input t_samp b);
        logic [7:0] r;
        if (a >= b) begin
            r = a - b;
        end else begin
            r = b - a;
        end
        return r;
    endfunction

endpackage

### rtl/hldb_in_if.sv
// Input channel: one four-line edge segment with its thresholds and keep flags.
`timescale 1ns / 1ps
interface hldb_in_if;
    import hldb_pkg::*;

    logic        valid;
    logic        ready;
    t_line       line_0;
    t_line       line_1;
    t_line       line_2;
    t_line       line_3;
    logic [6:0]  beta;
    logic [4:0]  tc;
    logic        keep_p;
    logic        keep_q;

    modport source (output valid, output line_0, output line_1, output line_2,
                    output line_3, output beta, output tc, output keep_p,
                    output keep_q, input ready);
    modport sink   (input valid, input line_0, input line_1, input line_2,
                    input line_3, input beta, input tc, input keep_p,
                    input keep_q, output ready);
endinterface

### rtl/hldb_out_if.sv
// Output channel: four filtered lines and the filter mode applied.
`timescale 1ns / 1ps
interface hldb_out_if;
    import hldb_pkg::*;

    logic        valid;
    logic        ready;
    t_line       out_line_0;
    t_line       out_line_1;
    t_line       out_line_2;
    t_line       out_line_3;
    logic [1:0]  filter_mode;

    modport source (output valid, output out_line_0, output out_line_1,
                    output out_line_2, output out_line_3, output filter_mode,
                    input ready);
    modport sink   (input valid, input out_line_0, input out_line_1,
                    input out_line_2, input out_line_3, input filter_mode,
                    output ready);
endinterface

### rtl/hldb_lane.sv
// Per-line lane: strong and weak filter candidates for one line, registered.
`timescale 1ns / 1ps
module hldb_lane (
    input  logic               i_clk,
    input  logic               i_en,
    input  hldb_pkg::t_line    i_line,
    input  logic [4:0]         i_tc,
    output hldb_pkg::t_lane_res o_res
);
    import hldb_pkg::*;

    t_samp p3, p2, p1, p0, q0, q1, q2, q3;
    logic [10:0] e3p, e2p, e1p, e0p, e0q, e1q, e2q, e3q;
    logic [10:0] s_p0, s_p1, s_p2, s_q0, s_q1, s_q2;
    logic [5:0]  tc2;
    logic [4:0]  htc;
    logic signed [13:0] dw;
    logic signed [13:0] dsh;
    logic signed [9:0]  delta;
    logic [8:0]  adelta;
    logic [8:0]  tc10;
    logic signed [10:0] dc;
    logic signed [10:0] d1p_raw, d1q_raw, d1p, d1q;
    logic [8:0]  avg_p, avg_q;
    t_lane_res   n_res;
    t_lane_res   r_res;

    always_comb begin
        p3 = get_samp(i_line, IDX_P3);
        p2 = get_samp(i_line, IDX_P2);
        p1 = get_samp(i_line, IDX_P1);
        p0 = get_samp(i_line, IDX_P0);
        q0 = get_samp(i_line, IDX_Q0);
        q1 = get_samp(i_line, IDX_Q1);
        q2 = get_samp(i_line, IDX_Q2);
        q3 = get_samp(i_line, IDX_Q3);
        e3p = {3'b0, p3};
        e2p = {3'b0, p2};
        e1p = {3'b0, p1};
        e0p = {3'b0, p0};
        e0q = {3'b0, q0};
        e1q = {3'b0, q1};
        e2q = {3'b0, q2};
        e3q = {3'b0, q3};

        s_p0 = (e2p + (e1p << 1) + (e0p << 1) + (e0q << 1) + e1q + 11'd4) >> 3;
        s_p1 = (e2p + e1p + e0p + e0q + 11'd2) >> 2;
        s_p2 = ((e3p << 1) + (e2p << 1) + e2p + e1p + e0p + e0q + 11'd4) >> 3;
        s_q0 = (e1p + (e0p << 1) + (e0q << 1) + (e1q << 1) + e2q + 11'd4) >> 3;
        s_q1 = (e0p + e0q + e1q + e2q + 11'd2) >> 2;
        s_q2 = (e0p + e0q + e1q + (e2q << 1) + e2q + (e3q << 1) + 11'd4) >> 3;
        tc2  = {i_tc, 1'b0};
        htc  = {1'b0, i_tc[4:1]};

        dw = 14'sd9 * ($signed({6'b0, q0}) - $signed({6'b0, p0}))
           - 14'sd3 * ($signed({6'b0, q1}) - $signed({6'b0, p1})) + 14'sd8;
        dsh    = dw >>> 4;
        delta  = dsh[9:0];
        adelta = delta[9] ? 9'(-delta) : delta[8:0];
        tc10   = 9'({4'b0, i_tc} * 9'd10);
        dc     = clamp_sym(11'(delta), i_tc);

        avg_p   = ({1'b0, p2} + {1'b0, p0} + 9'd1) >> 1;
        avg_q   = ({1'b0, q2} + {1'b0, q0} + 9'd1) >> 1;
        d1p_raw = ($signed({3'b0, avg_p[7:0]}) - $signed({3'b0, p1}) + dc) >>> 1;
        d1q_raw = ($signed({3'b0, avg_q[7:0]}) - $signed({3'b0, q1}) - dc) >>> 1;
        d1p     = clamp_sym(d1p_raw, htc);
        d1q     = clamp_sym(d1q_raw, htc);

        n_res.orig    = i_line;
        n_res.sp0     = hold(s_p0[7:0], p0, tc2);
        n_res.sp1     = hold(s_p1[7:0], p1, tc2);
        n_res.sp2     = hold(s_p2[7:0], p2, tc2);
        n_res.sq0     = hold(s_q0[7:0], q0, tc2);
        n_res.sq1     = hold(s_q1[7:0], q1, tc2);
        n_res.sq2     = hold(s_q2[7:0], q2, tc2);
        n_res.weak_ok = adelta < tc10;
        n_res.wp0     = clip8($signed({3'b0, p0}) + dc);
        n_res.wq0     = clip8($signed({3'b0, q0}) - dc);
        n_res.wp1     = clip8($signed({3'b0, p1}) + d1p);
        n_res.wq1     = clip8($signed({3'b0, q1}) + d1q);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_res <= n_res;
        end
    end

    assign o_res = r_res;
endmodule

### rtl/hldb_decide.sv
// Segment decision from lines 0 and 3: none, weak or strong, plus side flatness.
`timescale 1ns / 1ps
module hldb_decide (
    input  logic            i_clk,
    input  logic            i_en,
    input  hldb_pkg::t_line i_line_0,
    input  hldb_pkg::t_line i_line_3,
    input  logic [6:0]      i_beta,
    input  logic [4:0]      i_tc,
    input  logic            i_keep_p,
    input  logic            i_keep_q,
    output hldb_pkg::t_ctrl o_ctrl
);
    import hldb_pkg::*;

    function automatic logic [8:0] sec_diff(input t_samp a, input t_samp b, input t_samp c);
        logic signed [10:0] v;
        logic [8:0] r;
        v = $signed({3'b0, a}) - $signed({2'b0, b, 1'b0}) + $signed({3'b0, c});
        r = v[10] ? 9'(-v) : v[8:0];
        return r;
    endfunction

    function automatic logic strong_line(input t_line l, input logic [9:0] dpq,
                                         input logic [6:0] beta, input logic [7:0] thr);
        logic [8:0] flat;
        flat = {1'b0, abs_diff(get_samp(l, IDX_P3), get_samp(l, IDX_P0))}
             + {1'b0, abs_diff(get_samp(l, IDX_Q0), get_samp(l, IDX_Q3))};
        return ({1'b0, dpq, 1'b0} < {7'b0, beta[6:2]})
            && (flat < {5'b0, beta[6:3]})
            && (abs_diff(get_samp(l, IDX_P0), get_samp(l, IDX_Q0)) < thr);
    endfunction

    logic [8:0]  dp0, dp3, dq0, dq3;
    logic [9:0]  dpq0, dpq3, dp, dq;
    logic [10:0] total;
    logic [7:0]  thr;
    logic [7:0]  side;
    logic        go_strong;
    t_ctrl       n_ctrl;
    t_ctrl       r_ctrl;

    always_comb begin
        dp0 = sec_diff(get_samp(i_line_0, IDX_P2), get_samp(i_line_0, IDX_P1),
                       get_samp(i_line_0, IDX_P0));
        dp3 = sec_diff(get_samp(i_line_3, IDX_P2), get_samp(i_line_3, IDX_P1),
                       get_samp(i_line_3, IDX_P0));
        dq0 = sec_diff(get_samp(i_line_0, IDX_Q2), get_samp(i_line_0, IDX_Q1),
                       get_samp(i_line_0, IDX_Q0));
        dq3 = sec_diff(get_samp(i_line_3, IDX_Q2), get_samp(i_line_3, IDX_Q1),
                       get_samp(i_line_3, IDX_Q0));
        dpq0  = {1'b0, dp0} + {1'b0, dq0};
        dpq3  = {1'b0, dp3} + {1'b0, dq3};
        dp    = {1'b0, dp0} + {1'b0, dp3};
        dq    = {1'b0, dq0} + {1'b0, dq3};
        total = {1'b0, dpq0} + {1'b0, dpq3};
        thr   = 8'(({3'b0, i_tc} << 2) + {3'b0, i_tc} + 8'd1) >> 1;
        side  = 8'({1'b0, i_beta} + {2'b0, i_beta[6:1]}) >> 3;
        go_strong = strong_line(i_line_0, dpq0, i_beta, thr)
                 && strong_line(i_line_3, dpq3, i_beta, thr);

        if (total >= {4'b0, i_beta}) begin
            n_ctrl.mode = MODE_NONE;
        end else if (go_strong) begin
            n_ctrl.mode = MODE_STRONG;
        end else begin
            n_ctrl.mode = MODE_WEAK;
        end
        n_ctrl.flat_p = dp < {2'b0, side};
        n_ctrl.flat_q = dq < {2'b0, side};
        n_ctrl.keep_p = i_keep_p;
        n_ctrl.keep_q = i_keep_q;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ctrl <= n_ctrl;
        end
    end

    assign o_ctrl = r_ctrl;
endmodule

### rtl/hldb_merge.sv
// Merge stage: pick each line's samples from the lane candidates by the segment decision.
`timescale 1ns / 1ps
module hldb_merge (
    input  logic                i_clk,
    input  logic                i_en,
    input  hldb_pkg::t_ctrl     i_ctrl,
    input  hldb_pkg::t_lane_res i_res [hldb_pkg::NLINES],
    output hldb_pkg::t_line     o_lines [hldb_pkg::NLINES],
    output hldb_pkg::t_mode     o_mode
);
    import hldb_pkg::*;

    t_line n_lines [NLINES];
    t_line r_lines [NLINES];
    t_mode r_mode;

    always_comb begin
        for (int i = 0; i < NLINES; i++) begin
            n_lines[i] = i_res[i].orig;
            case (i_ctrl.mode)
                MODE_STRONG: begin
                    if (!i_ctrl.keep_p) begin
                        n_lines[i][IDX_P2*SAMP_W +: SAMP_W] = i_res[i].sp2;
                        n_lines[i][IDX_P1*SAMP_W +: SAMP_W] = i_res[i].sp1;
                        n_lines[i][IDX_P0*SAMP_W +: SAMP_W] = i_res[i].sp0;
                    end
                    if (!i_ctrl.keep_q) begin
                        n_lines[i][IDX_Q0*SAMP_W +: SAMP_W] = i_res[i].sq0;
                        n_lines[i][IDX_Q1*SAMP_W +: SAMP_W] = i_res[i].sq1;
                        n_lines[i][IDX_Q2*SAMP_W +: SAMP_W] = i_res[i].sq2;
                    end
                end
                MODE_WEAK: begin
                    if (i_res[i].weak_ok) begin
                        if (!i_ctrl.keep_p) begin
                            n_lines[i][IDX_P0*SAMP_W +: SAMP_W] = i_res[i].wp0;
                            if (i_ctrl.flat_p) begin
                                n_lines[i][IDX_P1*SAMP_W +: SAMP_W] = i_res[i].wp1;
                            end
                        end
                        if (!i_ctrl.keep_q) begin
                            n_lines[i][IDX_Q0*SAMP_W +: SAMP_W] = i_res[i].wq0;
                            if (i_ctrl.flat_q) begin
                                n_lines[i][IDX_Q1*SAMP_W +: SAMP_W] = i_res[i].wq1;
                            end
                        end
                    end
                end
                default: begin
                    n_lines[i] = i_res[i].orig;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_lines <= n_lines;
            r_mode  <= i_ctrl.mode;
        end
    end

    assign o_lines = r_lines;
    assign o_mode  = r_mode;
endmodule

### rtl/hevc_luma_deblock_segment.sv
// Top level of the four-line luma deblocking segment filter.
// Pipeline: lane/decision stage, then merge stage; both register their results.
// Throughput: one item per cycle; each stage advances whenever the stage after it is free.
// The output register holds a finished item while the lanes already take the next.
// Reset (synchronous, active low) clears both stage valid flags; data registers keep contents.
`timescale 1ns / 1ps
module hevc_luma_deblock_segment (
    input  logic              i_clk,
    input  logic              i_rst_n,
    hldb_in_if.sink           i_in,
    hldb_out_if.source        o_out
);
    import hldb_pkg::*;

    logic      r_v1;
    logic      r_v2;
    logic      en1;
    logic      en2;
    t_line     w_lines [NLINES];
    t_lane_res w_res [NLINES];
    t_ctrl     w_ctrl;
    t_line     w_out [NLINES];
    t_mode     w_mode;

    assign en2        = !r_v2 || o_out.ready;
    assign en1        = !r_v1 || en2;
    assign i_in.ready = en1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (en1) begin
                r_v1 <= i_in.valid;
            end
            if (en2) begin
                r_v2 <= r_v1;
            end
        end
    end

    assign w_lines[0] = i_in.line_0;
    assign w_lines[1] = i_in.line_1;
    assign w_lines[2] = i_in.line_2;
    assign w_lines[3] = i_in.line_3;

    for (genvar g = 0; g < NLINES; g++) begin : g_lane
        hldb_lane u_lane (
            .i_clk  (i_clk),
            .i_en   (en1 && i_in.valid),
            .i_line (w_lines[g]),
            .i_tc   (i_in.tc),
            .o_res  (w_res[g])
        );
    end

    hldb_decide u_decide (
        .i_clk    (i_clk),
        .i_en     (en1 && i_in.valid),
        .i_line_0 (w_lines[0]),
        .i_line_3 (w_lines[NLINES-1]),
        .i_beta   (i_in.beta),
        .i_tc     (i_in.tc),
        .i_keep_p (i_in.keep_p),
        .i_keep_q (i_in.keep_q),
        .o_ctrl   (w_ctrl)
    );

    hldb_merge u_merge (
        .i_clk   (i_clk),
        .i_en    (en2 && r_v1),
        .i_ctrl  (w_ctrl),
        .i_res   (w_res),
        .o_lines (w_out),
        .o_mode  (w_mode)
    );

    assign o_out.valid       = r_v2;
    assign o_out.out_line_0  = w_out[0];
    assign o_out.out_line_1  = w_out[1];
    assign o_out.out_line_2  = w_out[2];
    assign o_out.out_line_3  = w_out[3];
    assign o_out.filter_mode = w_mode;
endmodule
